@@ rtl/core/sorted_timestamp_insert_table_macros.svh @@
// Assertion macros shared by the sorted timestamp insert table.
`ifndef SORTED_TIMESTAMP_INSERT_TABLE_MACROS_SVH
`define SORTED_TIMESTAMP_INSERT_TABLE_MACROS_SVH

// Checks a property on every rising edge of clk while the block is out of reset.
`define STIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge of clk.
`define STIT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/stit_pkg.sv @@
// Package of types and constants for the sorted timestamp insert table.
package stit_pkg;

	localparam int DAY_W      = 7;
	localparam int HOUR_W     = 7;
	localparam int MINUTE_W   = 7;
	localparam int IN_PAY_W   = 16;
	localparam int RIDX_W     = 6;
	localparam int S_DATA_W   = 48;

	localparam int COUNT_W    = 7;
	localparam int ODAY_W     = 5;
	localparam int OHOUR_W    = 5;
	localparam int OMIN_W     = 6;
	localparam int OUT_PAY_W  = 16;
	localparam int M_DATA_W   = 40;

	localparam int KEY_W      = ODAY_W + OHOUR_W + OMIN_W;

	localparam logic [DAY_W-1:0]    DAY_MAX    = 7'd31;
	localparam logic [HOUR_W-1:0]   HOUR_MAX   = 7'd23;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = 7'd59;
	localparam logic [DAY_W-1:0]    DAY_END    = 7'd0;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_BAD_DAY    = 3'd2,
		ST_BAD_HOUR   = 3'd3,
		ST_BAD_MINUTE = 3'd4,
		ST_END        = 3'd5,
		ST_EMPTY      = 3'd6
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

@@ rtl/core/stit_ctrl.sv @@
// Controller state machine of the sorted timestamp insert table.
module stit_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	output stit_pkg::cmd_t cmd
);
	import stit_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// The result register must be free, or emptied this cycle.
				if (out_free) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/stit_dpath.sv @@
// Datapath of the sorted timestamp insert table: item register, sorted cell row and result.
module stit_dpath #(
	parameter int TABLE_DEPTH  = 64,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stit_pkg::cmd_t                  cmd,
	input  logic [stit_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	output logic [stit_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [2:0]                      m_tuser
);
	import stit_pkg::*;

	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CMPW = (CW > RIDX_W) ? CW : RIDX_W;

	// Captured item.
	op_t                  op_q;
	logic [DAY_W-1:0]     day_q;
	logic [HOUR_W-1:0]    hour_q;
	logic [MINUTE_W-1:0]  minute_q;
	logic [IN_PAY_W-1:0]  payload_q;
	logic [RIDX_W-1:0]    ridx_q;

	// Sorted cell row.
	logic [KEY_W-1:0]        key_q [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_q [TABLE_DEPTH];
	logic [CW-1:0]           count_q;

	// Result register.
	status_t              res_status_q;
	logic [COUNT_W-1:0]   res_count_q;
	logic [KEY_W-1:0]     res_key_q;
	logic [OUT_PAY_W-1:0] res_pay_q;

	status_t              status;
	logic [KEY_W-1:0]     new_key;
	logic [TABLE_DEPTH-1:0] ge;
	logic [TABLE_DEPTH-1:0] take_new;
	logic                 ins_en;
	logic                 rd_ok;
	logic [IW-1:0]        rd_addr;
	logic [CW-1:0]        count_d;

	assign new_key = {day_q[ODAY_W-1:0], hour_q[OHOUR_W-1:0], minute_q[OMIN_W-1:0]};
	assign rd_ok   = CMPW'(ridx_q) < CMPW'(count_q);
	assign rd_addr = IW'(CMPW'(ridx_q));

	always_comb begin
		if (op_q == OP_READ) begin
			status = rd_ok ? ST_OK : ST_EMPTY;
		end else begin
			priority if (count_q >= CW'(TABLE_DEPTH)) begin
				status = ST_FULL;
			end else if (day_q == DAY_END) begin
				status = ST_END;
			end else if (day_q > DAY_MAX) begin
				status = ST_BAD_DAY;
			end else if (hour_q > HOUR_MAX) begin
				status = ST_BAD_HOUR;
			end else if (minute_q > MINUTE_MAX) begin
				status = ST_BAD_MINUTE;
			end else begin
				status = ST_OK;
			end
		end
	end

	assign ins_en  = cmd.execute && (op_q == OP_INSERT) && (status == ST_OK);
	assign count_d = ins_en ? count_q + CW'(1) : count_q;

	// A cell is at or past the insertion point when it is unused or its key is not smaller.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ge[i] = (CW'(i) >= count_q) || (key_q[i] >= new_key);
		end
		take_new[0] = ge[0];
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			take_new[i] = ge[i] && !ge[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op_t'(s_tuser);
			day_q     <= s_tdata[DAY_W-1:0];
			hour_q    <= s_tdata[DAY_W +: HOUR_W];
			minute_q  <= s_tdata[DAY_W+HOUR_W +: MINUTE_W];
			payload_q <= s_tdata[DAY_W+HOUR_W+MINUTE_W +: IN_PAY_W];
			ridx_q    <= s_tdata[DAY_W+HOUR_W+MINUTE_W+IN_PAY_W +: RIDX_W];
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (ins_en && ge[g]) begin
					key_q[g] <= new_key;
					pay_q[g] <= PAYLOAD_BITS'(payload_q);
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (ins_en && ge[g]) begin
					key_q[g] <= take_new[g] ? new_key : key_q[g-1];
					pay_q[g] <= take_new[g] ? PAYLOAD_BITS'(payload_q) : pay_q[g-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_status_q <= status;
			res_count_q  <= COUNT_W'(count_d);
			if ((op_q == OP_READ) && rd_ok) begin
				res_key_q <= key_q[rd_addr];
				res_pay_q <= OUT_PAY_W'(pay_q[rd_addr]);
			end else begin
				res_key_q <= '0;
				res_pay_q <= '0;
			end
		end
	end

	assign m_tuser = res_status_q;
	assign m_tdata = {1'b0, res_pay_q, res_key_q[OMIN_W-1:0],
		res_key_q[OMIN_W +: OHOUR_W], res_key_q[OMIN_W+OHOUR_W +: ODAY_W], res_count_q};

endmodule

@@ rtl/core/sorted_timestamp_insert_table.sv @@
// Top level of the sorted timestamp insert table.
//
// The block keeps up to TABLE_DEPTH entries sorted by a day/hour/minute key,
// each with a payload tag. Every input transaction on the s_ channel is either
// an insert or a read (selected by s_tuser) and yields exactly one result
// transaction on the m_ channel, carrying a status code in m_tuser.
// An insert is checked for a full table, the end marker and out-of-range
// fields; a valid one is placed before the first stored key that is not
// smaller, with the later entries moving up one place in the same cycle.
// A read returns the entry at the given sorted position.
// Each item is first captured, then the row of compare-and-shift cells updates
// and the result register loads. The result is visible on m_tvalid in the cycle
// after the result register loads. A new item is not accepted until the current
// one has executed.
// The result register separates the two sides: a new item is accepted while
// a result still waits, and the block only holds the captured item back when
// the receiver stalls with the result register occupied.
// Reset empties the table at once; the cell contents are not cleared and
// are never read before being written.
module sorted_timestamp_insert_table #(
	parameter int TABLE_DEPTH  = 64,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// day[6:0], hour[13:7], minute[20:14], payload[36:21], read_index[42:37], zero[47:43]
	input  logic [47:0] s_tdata,
	// operation[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// entry_count[6:0], out_day[11:7], out_hour[16:12], out_minute[22:17],
	// out_payload[38:23], zero[39]
	output logic [39:0] m_tdata,
	// status[2:0]
	output logic [2:0]  m_tuser
);
	import stit_pkg::*;

	`include "sorted_timestamp_insert_table_macros.svh"

	cmd_t cmd;

	stit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	stit_dpath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// After a transaction is taken in, the block is busy for the following cycle.
	`STIT_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted twice in a row")
	// Executing an item always presents its result in the next cycle.
	`STIT_ASSERT(a_result_follows, cmd.execute |=> m_tvalid, "result missing after execute")
	// A result that was taken is not shown again unless a new one was produced.
	`STIT_ASSERT(a_no_repeat, m_tvalid && m_tready && !cmd.execute |=> !m_tvalid, "result repeated")

endmodule

@@ test/stit_checker.sv @@
// Checker for the sorted timestamp insert table: predicts every result and compares it.
module stit_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [stit_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [stit_pkg::M_DATA_W-1:0] m_tdata,
	input  logic [2:0]                    m_tuser,
	output int                            failures,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import stit_pkg::*;

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic [ODAY_W-1:0]    day;
		logic [OHOUR_W-1:0]   hour;
		logic [OMIN_W-1:0]    minute;
		logic [OUT_PAY_W-1:0] payload;
	} outcome_t;

	logic [KEY_W-1:0]     key_row [TABLE_DEPTH];
	logic [OUT_PAY_W-1:0] tag_row [TABLE_DEPTH];
	int                   fill = 0;
	outcome_t             outcome_q [$];
	int                   err_count = 0;

	// Applies one transaction to the shadow table and returns the result it must give.
	function automatic outcome_t table_update(input op_t op, input logic [DAY_W-1:0] d,
			input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] mi,
			input logic [IN_PAY_W-1:0] tag, input logic [RIDX_W-1:0] idx);
		outcome_t         o;
		logic [KEY_W-1:0] key;
		int               pos;
		int               k;
		o = '0;
		if (op == OP_READ) begin
			if (int'(idx) < fill) begin
				o.status = ST_OK;
				{o.day, o.hour, o.minute} = key_row[idx];
				o.payload = tag_row[idx];
			end else begin
				o.status = ST_EMPTY;
			end
		end else if (fill >= TABLE_DEPTH) begin
			o.status = ST_FULL;
		end else if (d == DAY_END) begin
			o.status = ST_END;
		end else if (d > DAY_MAX) begin
			o.status = ST_BAD_DAY;
		end else if (h > HOUR_MAX) begin
			o.status = ST_BAD_HOUR;
		end else if (mi > MINUTE_MAX) begin
			o.status = ST_BAD_MINUTE;
		end else begin
			// The new entry goes ahead of every stored key that is not smaller.
			key = {d[ODAY_W-1:0], h[OHOUR_W-1:0], mi[OMIN_W-1:0]};
			pos = 0;
			while (pos < fill && key_row[pos] < key)
				pos++;
			for (k = fill; k > pos; k--) begin
				key_row[k] = key_row[k-1];
				tag_row[k] = tag_row[k-1];
			end
			key_row[pos] = key;
			tag_row[pos] = tag;
			fill++;
			o.status = ST_OK;
		end
		o.count = COUNT_W'(fill);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic compare_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				outcome_q.push_back(table_update(op_t'(s_tuser), s_tdata[6:0], s_tdata[13:7],
					s_tdata[20:14], s_tdata[36:21], s_tdata[42:37]));
			if (m_tvalid && m_tready) begin
				got.status  = status_t'(m_tuser);
				got.count   = m_tdata[6:0];
				got.day     = m_tdata[11:7];
				got.hour    = m_tdata[16:12];
				got.minute  = m_tdata[22:17];
				got.payload = m_tdata[38:23];
				if (outcome_q.size() == 0) begin
					report_mismatch("result transaction with nothing outstanding",
						got.status, 0);
				end else begin
					want = outcome_q.pop_front();
					compare_field("status", got.status, want.status);
					compare_field("entry_count", got.count, want.count);
					compare_field("out_day", got.day, want.day);
					compare_field("out_hour", got.hour, want.hour);
					compare_field("out_minute", got.minute, want.minute);
					compare_field("out_payload", got.payload, want.payload);
				end
			end
		end
		failures <= err_count;
		pending  <= outcome_q.size();
	end

endmodule

@@ test/tb_sorted_timestamp_insert_table.sv @@
// Testbench top for the sorted timestamp insert table: clock, reset, stimulus and verdict.
module tb_sorted_timestamp_insert_table;
	timeunit 1ns;
	timeprecision 1ps;
	import stit_pkg::*;

	localparam int TABLE_DEPTH   = 64;
	localparam int ITEM_COUNT    = 1450;
	// Long enough for the result register and the captured item to both fill up.
	localparam int HOLD_CYCLES   = 150;
	// A result appears on m_tvalid once its transaction has been captured and executed.
	localparam int SETTLE_CYCLES = 8;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// day, hour, minute, payload, read_index from the lowest bit up
	logic [S_DATA_W-1:0] s_tdata  = '0;
	// operation
	logic                s_tuser  = OP_INSERT;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// entry_count, out_day, out_hour, out_minute, out_payload from the lowest bit up
	logic [M_DATA_W-1:0] m_tdata;
	// status
	logic [2:0]          m_tuser;
	int                  failures;
	int                  pending;

	// Entries that the stimulus has inserted successfully, used to aim reads at filled rows.
	int                  filled = 0;
	// Each increment asks the result sink for one long hold-off.
	int                  hold_requests = 0;
	// While a burst flag is set that side neither idles nor stalls, a requested long hold-off apart.
	bit                  tx_burst = 1'b0;
	bit                  rx_burst = 1'b0;
	// The last key inserted, reused now and then so that equal keys meet in the table.
	logic [DAY_W-1:0]    tie_day;
	logic [HOUR_W-1:0]   tie_hour;
	logic [MINUTE_W-1:0] tie_minute;

	always #2 clk = ~clk;

	sorted_timestamp_insert_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PAYLOAD_BITS(IN_PAY_W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	stit_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.failures(failures),
		.pending (pending)
	);

	// Offers one transaction after a random gap and returns at the edge that accepts it.
	// The valid is only lowered when a gap follows, so back-to-back transactions keep
	// it high without a second assignment in the same time step.
	task automatic send_item(input op_t op, input logic [DAY_W-1:0] d,
			input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] mi,
			input logic [IN_PAY_W-1:0] tag, input logic [RIDX_W-1:0] idx);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= S_DATA_W'({idx, tag, mi, h, d});
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Inserts an entry that passes every check; the read index rides along as noise.
	task automatic add_entry(input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
			input logic [MINUTE_W-1:0] mi, input logic [IN_PAY_W-1:0] tag);
		tie_day    = d;
		tie_hour   = h;
		tie_minute = mi;
		if (filled < TABLE_DEPTH)
			filled++;
		send_item(OP_INSERT, d, h, mi, tag, RIDX_W'($urandom()));
	endtask

	task automatic send_valid_insert();
		logic [DAY_W-1:0]    d;
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] mi;
		if (filled > 0 && $urandom_range(0, 3) == 0) begin
			d  = tie_day;
			h  = tie_hour;
			mi = tie_minute;
		end else begin
			d  = DAY_W'($urandom_range(1, DAY_MAX));
			h  = HOUR_W'($urandom_range(0, HOUR_MAX));
			mi = MINUTE_W'($urandom_range(0, MINUTE_MAX));
		end
		add_entry(d, h, mi, IN_PAY_W'($urandom()));
	endtask

	// An insert that fails one check. Fields checked later may be out of range as well,
	// since only the first failing check decides the status.
	task automatic send_bad_insert();
		logic [DAY_W-1:0]    d;
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] mi;
		d  = DAY_W'($urandom_range(1, DAY_MAX));
		h  = HOUR_W'($urandom_range(0, HOUR_MAX));
		mi = MINUTE_W'($urandom_range(0, MINUTE_MAX));
		case ($urandom_range(0, 3))
			0: begin
				d  = DAY_END;
				h  = HOUR_W'($urandom());
				mi = MINUTE_W'($urandom());
			end
			1: begin
				d  = DAY_W'($urandom_range(DAY_MAX + 1, 2**DAY_W - 1));
				h  = HOUR_W'($urandom());
				mi = MINUTE_W'($urandom());
			end
			2: begin
				h  = HOUR_W'($urandom_range(HOUR_MAX + 1, 2**HOUR_W - 1));
				mi = MINUTE_W'($urandom());
			end
			default: mi = MINUTE_W'($urandom_range(MINUTE_MAX + 1, 2**MINUTE_W - 1));
		endcase
		send_item(OP_INSERT, d, h, mi, IN_PAY_W'($urandom()), RIDX_W'($urandom()));
	endtask

	// Reads mostly hit filled rows; the rest take any index, empty rows included.
	// The insert fields carry random junk that the block must ignore.
	task automatic send_read();
		logic [RIDX_W-1:0] idx;
		if (filled > 0 && $urandom_range(0, 3) != 0)
			idx = RIDX_W'($urandom_range(0, filled - 1));
		else
			idx = RIDX_W'($urandom());
		send_item(OP_READ, DAY_W'($urandom()), HOUR_W'($urandom()), MINUTE_W'($urandom()),
			IN_PAY_W'($urandom()), idx);
	endtask

	// Stops offering and waits until every expected result has arrived. The first edge
	// lets the checker count a transaction accepted in the current step.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result sink: a random stall before each result, with bursts of none, and one long
	// hold-off per request from the stimulus, counted here in cycles.
	initial begin : result_sink
		int stall;
		int holds_served;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 4);
			if (holds_served != hold_requests) begin
				stall = HOLD_CYCLES;
				holds_served++;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int n;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: an empty table, every rejection of an insert but a full table, the extremes of the
		// key and payload, equal keys, and reads on both sides of the entry count.
		send_item(OP_READ, '0, '0, '0, '0, '0);
		send_item(OP_READ, '1, '1, '1, '1, '1);
		send_item(OP_INSERT, DAY_END, 7'd5, 7'd5, 16'h1111, '0);
		send_item(OP_INSERT, DAY_MAX + 7'd1, 7'd0, 7'd0, 16'h2222, '0);
		send_item(OP_INSERT, '1, '1, '1, '1, '1);
		send_item(OP_INSERT, 7'd1, HOUR_MAX + 7'd1, 7'd0, 16'h3333, '0);
		send_item(OP_INSERT, DAY_MAX, '1, '1, 16'h4444, '0);
		send_item(OP_INSERT, 7'd5, HOUR_MAX, MINUTE_MAX + 7'd1, 16'h5555, '0);
		send_item(OP_INSERT, 7'd5, 7'd0, '1, 16'h6666, '0);
		add_entry(DAY_MAX, HOUR_MAX, MINUTE_MAX, '1);
		add_entry(7'd1, 7'd0, 7'd0, '0);
		add_entry(7'd15, 7'd12, 7'd30, 16'hAAAA);
		// An equal key must land ahead of the entry already stored.
		add_entry(7'd15, 7'd12, 7'd30, 16'h5555);
		add_entry(7'd16, 7'd0, 7'd0, 16'h1234);
		for (n = 0; n <= filled; n++)
			send_item(OP_READ, '1, '1, '1, '1, RIDX_W'(n));
		send_item(OP_READ, '0, '0, '0, '0, '1);

		// Random part. Until the table is full most transactions are well-formed
		// inserts and reads; after that inserts can only be refused, so reads dominate.
		for (n = 0; n < ITEM_COUNT; n++) begin
			if (n == 60 || n == 900)
				hold_requests++;
			if (n == 150 || n == 1200)
				wait_until_drained();
			pick = $urandom_range(0, 99);
			if (filled < TABLE_DEPTH) begin
				if (pick < 35)
					send_valid_insert();
				else if (pick < 55)
					send_bad_insert();
				else
					send_read();
			end else begin
				if (pick < 10)
					send_valid_insert();
				else if (pick < 20)
					send_bad_insert();
				else
					send_read();
			end
		end

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// A correct run needs well under a tenth of this.
	initial begin : watchdog
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/stit_pkg.sv
rtl/core/stit_ctrl.sv
rtl/core/stit_dpath.sv
rtl/core/sorted_timestamp_insert_table.sv
test/stit_checker.sv
test/tb_sorted_timestamp_insert_table.sv
